// ----- hw/rtl/alm_pkg.sv -----
package alm_pkg;

    // store geometry
    localparam int DEPTH  = 256;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int PTR_W  = $clog2(DEPTH + 1);

    // pointer into the node store, the value DEPTH marks null
    typedef logic [PTR_W-1:0] ptr_t;

    localparam ptr_t NIL = ptr_t'(DEPTH);

    // request opcodes
    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_REAR  = 3'd1,
        OP_REM_FRONT = 3'd2,
        OP_REM_REAR  = 3'd3,
        OP_REM_CUR   = 3'd4,
        OP_SEARCH    = 3'd5,
        OP_CLEAR     = 3'd6,
        OP_NOP       = 3'd7
    } opcode_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_NO_CUR    = 3'd4
    } status_t;

    // pointer refers to a real slot
    function automatic logic ptr_live(ptr_t p);
        return p < NIL;
    endfunction

endpackage

// ----- hw/rtl/alm_ram.sv -----
module alm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/array_linked_list_manager.sv -----
// channel   direction  handshake            content
// request   in         in_valid / in_stall  opcode, payload
// result    out        out_valid / out_stall status, has_current, current_index,
//                                           current_payload, is_empty
// config    in         cfg_valid / cfg_ready match_mask
//
// one request at a time; a nop, a refusal, an empty list, a front remove and a front
// insert need no walk, while rear inserts, rear removes, searches and removes of a
// current node below the head walk the list from the head node by node
// rst_n clears the pointers and high-water count and sets the mask to all ones; node
// contents are never used before written, so the memories get no clearing pass
// out_stall holds a finished result in the output register and the sequencer with it
module array_linked_list_manager (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [2:0]                 opcode,
    input  logic [alm_pkg::DATA_W-1:0] payload,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [2:0]                 status,
    output logic                       has_current,
    output logic [alm_pkg::IDX_W-1:0]  current_index,
    output logic [alm_pkg::DATA_W-1:0] current_payload,
    output logic                       is_empty,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [31:0]                match_mask
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK,
        S_ALLOC,
        S_TAKE,
        S_WRITE,
        S_LINK_TAIL,
        S_DROP,
        S_RC_FIX,
        S_RELEASE,
        S_FINISH,
        S_RESULT
    } state_t;

    state_t                       state_reg,       state_next;
    alm_pkg::opcode_t             op_reg,          op_next;
    logic [alm_pkg::DATA_W-1:0]   data_reg,        data_next;
    alm_pkg::status_t             st_reg,          st_next;
    logic [31:0]                  mask_reg,        mask_next;
    alm_pkg::ptr_t                head_reg,        head_next;
    alm_pkg::ptr_t                cur_reg,         cur_next;
    alm_pkg::ptr_t                hw_reg,          hw_next;
    alm_pkg::ptr_t                free_reg,        free_next;
    alm_pkg::ptr_t                p_reg,           p_next;
    alm_pkg::ptr_t                pre_reg,         pre_next;
    alm_pkg::ptr_t                slot_reg,        slot_next;
    alm_pkg::ptr_t                rel_reg,         rel_next;
    logic                         out_valid_reg,   out_valid_next;
    logic [2:0]                   status_reg,      status_next;
    logic                         has_cur_reg,     has_cur_next;
    logic [alm_pkg::IDX_W-1:0]    cur_idx_reg,     cur_idx_next;
    logic [alm_pkg::DATA_W-1:0]   cur_data_reg,    cur_data_next;
    logic                         is_empty_reg,    is_empty_next;

    // memory ports
    logic [alm_pkg::IDX_W-1:0]    rd_addr;
    logic                         link_we;
    logic [alm_pkg::IDX_W-1:0]    link_waddr;
    alm_pkg::ptr_t                link_wdata;
    alm_pkg::ptr_t                link_rdata;
    logic                         data_we;
    logic [alm_pkg::IDX_W-1:0]    data_waddr;
    logic [alm_pkg::DATA_W-1:0]   data_rdata;

    logic                         empty;
    logic                         full;
    logic                         hit;
    logic                         out_free;

    // node link store
    alm_ram #(
        .WIDTH (alm_pkg::PTR_W),
        .DEPTH (alm_pkg::DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (rd_addr),
        .rdata (link_rdata)
    );

    // node payload store
    alm_ram #(
        .WIDTH (alm_pkg::DATA_W),
        .DEPTH (alm_pkg::DEPTH)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_reg),
        .raddr (rd_addr),
        .rdata (data_rdata)
    );

    // status helpers
    assign empty    = !alm_pkg::ptr_live(head_reg);
    assign full     = !alm_pkg::ptr_live(free_reg) && (hw_reg >= alm_pkg::NIL);
    assign hit      = ((data_rdata ^ data_reg) & mask_reg) == '0;
    assign out_free = !out_valid_reg || !out_stall;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        data_next      = data_reg;
        st_next        = st_reg;
        mask_next      = mask_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        hw_next        = hw_reg;
        free_next      = free_reg;
        p_next         = p_reg;
        pre_next       = pre_reg;
        slot_next      = slot_reg;
        rel_next       = rel_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        has_cur_next   = has_cur_reg;
        cur_idx_next   = cur_idx_reg;
        cur_data_next  = cur_data_reg;
        is_empty_next  = is_empty_reg;
        rd_addr        = cur_reg[alm_pkg::IDX_W-1:0];
        link_we        = 1'b0;
        link_waddr     = p_reg[alm_pkg::IDX_W-1:0];
        link_wdata     = alm_pkg::NIL;
        data_we        = 1'b0;
        data_waddr     = slot_reg[alm_pkg::IDX_W-1:0];

        // config write; the user issues it only while idle, the block does not enforce it
        if (cfg_valid)
        begin
            mask_next = match_mask;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = alm_pkg::opcode_t'(opcode);
                    data_next  = payload;
                    st_next    = alm_pkg::ST_OK;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                rd_addr  = head_reg[alm_pkg::IDX_W-1:0];
                p_next   = head_reg;
                pre_next = alm_pkg::NIL;
                unique case (op_reg)
                    alm_pkg::OP_INS_FRONT, alm_pkg::OP_INS_REAR:
                    begin
                        if (full)
                        begin
                            st_next    = alm_pkg::ST_FULL;
                            state_next = S_FINISH;
                        end
                        else if (op_reg == alm_pkg::OP_INS_FRONT || empty)
                        begin
                            state_next = S_ALLOC;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                    alm_pkg::OP_REM_FRONT:
                    begin
                        if (empty)
                        begin
                            st_next    = alm_pkg::ST_EMPTY;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_DROP;
                        end
                    end
                    alm_pkg::OP_REM_REAR, alm_pkg::OP_SEARCH:
                    begin
                        if (empty)
                        begin
                            st_next    = alm_pkg::ST_EMPTY;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                    alm_pkg::OP_REM_CUR:
                    begin
                        if (empty)
                        begin
                            st_next    = alm_pkg::ST_EMPTY;
                            state_next = S_FINISH;
                        end
                        else if (!alm_pkg::ptr_live(cur_reg))
                        begin
                            st_next    = alm_pkg::ST_NO_CUR;
                            state_next = S_FINISH;
                        end
                        else if (cur_reg == head_reg)
                        begin
                            state_next = S_DROP;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                    alm_pkg::OP_CLEAR:
                    begin
                        if (empty)
                        begin
                            cur_next   = alm_pkg::NIL;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_DROP;
                        end
                    end
                    alm_pkg::OP_NOP:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            // one node per cycle, link and payload of p_reg arrive now
            S_WALK:
            begin
                unique case (op_reg)
                    alm_pkg::OP_SEARCH:
                    begin
                        if (hit)
                        begin
                            cur_next   = p_reg;
                            state_next = S_FINISH;
                        end
                        else if (alm_pkg::ptr_live(link_rdata))
                        begin
                            rd_addr = link_rdata[alm_pkg::IDX_W-1:0];
                            p_next  = link_rdata;
                        end
                        else
                        begin
                            st_next    = alm_pkg::ST_NOT_FOUND;
                            state_next = S_FINISH;
                        end
                    end
                    alm_pkg::OP_REM_CUR:
                    begin
                        if (link_rdata == cur_reg)
                        begin
                            rd_addr    = cur_reg[alm_pkg::IDX_W-1:0];
                            state_next = S_RC_FIX;
                        end
                        else if (alm_pkg::ptr_live(link_rdata))
                        begin
                            rd_addr = link_rdata[alm_pkg::IDX_W-1:0];
                            p_next  = link_rdata;
                        end
                        else
                        begin
                            st_next    = alm_pkg::ST_NO_CUR;
                            state_next = S_FINISH;
                        end
                    end
                    default:
                    begin
                        // tail search for rear insert and rear remove
                        if (alm_pkg::ptr_live(link_rdata))
                        begin
                            rd_addr  = link_rdata[alm_pkg::IDX_W-1:0];
                            pre_next = p_reg;
                            p_next   = link_rdata;
                        end
                        else if (op_reg == alm_pkg::OP_INS_REAR)
                        begin
                            state_next = S_ALLOC;
                        end
                        else
                        begin
                            if (alm_pkg::ptr_live(pre_reg))
                            begin
                                link_we    = 1'b1;
                                link_waddr = pre_reg[alm_pkg::IDX_W-1:0];
                                link_wdata = alm_pkg::NIL;
                                cur_next   = pre_reg;
                            end
                            else
                            begin
                                head_next = alm_pkg::NIL;
                                cur_next  = alm_pkg::NIL;
                            end
                            rel_next   = p_reg;
                            state_next = S_RELEASE;
                        end
                    end
                endcase
            end

            // fetch the link of the free list head
            S_ALLOC:
            begin
                rd_addr    = free_reg[alm_pkg::IDX_W-1:0];
                state_next = S_TAKE;
            end

            S_TAKE:
            begin
                if (alm_pkg::ptr_live(free_reg))
                begin
                    slot_next = free_reg;
                    free_next = link_rdata;
                end
                else
                begin
                    slot_next = hw_reg;
                    hw_next   = hw_reg + alm_pkg::PTR_W'(1);
                end
                state_next = S_WRITE;
            end

            // write the new node
            S_WRITE:
            begin
                data_we    = 1'b1;
                link_we    = 1'b1;
                link_waddr = slot_reg[alm_pkg::IDX_W-1:0];
                cur_next   = slot_reg;
                if (op_reg == alm_pkg::OP_INS_FRONT || empty)
                begin
                    link_wdata = head_reg;
                    head_next  = slot_reg;
                    state_next = S_FINISH;
                end
                else
                begin
                    link_wdata = alm_pkg::NIL;
                    state_next = S_LINK_TAIL;
                end
            end

            S_LINK_TAIL:
            begin
                link_we    = 1'b1;
                link_waddr = p_reg[alm_pkg::IDX_W-1:0];
                link_wdata = slot_reg;
                state_next = S_FINISH;
            end

            // unlink the head, repeated for clear
            S_DROP:
            begin
                link_we    = 1'b1;
                link_waddr = head_reg[alm_pkg::IDX_W-1:0];
                link_wdata = free_reg;
                free_next  = head_reg;
                head_next  = link_rdata;
                cur_next   = link_rdata;
                if (op_reg == alm_pkg::OP_CLEAR && alm_pkg::ptr_live(link_rdata))
                begin
                    rd_addr = link_rdata[alm_pkg::IDX_W-1:0];
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            // bypass the current node
            S_RC_FIX:
            begin
                link_we    = 1'b1;
                link_waddr = p_reg[alm_pkg::IDX_W-1:0];
                link_wdata = link_rdata;
                rel_next   = cur_reg;
                cur_next   = p_reg;
                state_next = S_RELEASE;
            end

            // push a slot on the free list
            S_RELEASE:
            begin
                link_we    = 1'b1;
                link_waddr = rel_reg[alm_pkg::IDX_W-1:0];
                link_wdata = free_reg;
                free_next  = rel_reg;
                state_next = S_FINISH;
            end

            // read the current payload
            S_FINISH:
            begin
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    is_empty_next  = empty;
                    if (alm_pkg::ptr_live(cur_reg))
                    begin
                        has_cur_next  = 1'b1;
                        cur_idx_next  = cur_reg[alm_pkg::IDX_W-1:0];
                        cur_data_next = data_rdata;
                    end
                    else
                    begin
                        has_cur_next  = 1'b0;
                        cur_idx_next  = '0;
                        cur_data_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= alm_pkg::OP_NOP;
            data_reg      <= '0;
            st_reg        <= alm_pkg::ST_OK;
            mask_reg      <= '1;
            head_reg      <= alm_pkg::NIL;
            cur_reg       <= alm_pkg::NIL;
            hw_reg        <= '0;
            free_reg      <= alm_pkg::NIL;
            p_reg         <= alm_pkg::NIL;
            pre_reg       <= alm_pkg::NIL;
            slot_reg      <= alm_pkg::NIL;
            rel_reg       <= alm_pkg::NIL;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            has_cur_reg   <= 1'b0;
            cur_idx_reg   <= '0;
            cur_data_reg  <= '0;
            is_empty_reg  <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            data_reg      <= data_next;
            st_reg        <= st_next;
            mask_reg      <= mask_next;
            head_reg      <= head_next;
            cur_reg       <= cur_next;
            hw_reg        <= hw_next;
            free_reg      <= free_next;
            p_reg         <= p_next;
            pre_reg       <= pre_next;
            slot_reg      <= slot_next;
            rel_reg       <= rel_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            has_cur_reg   <= has_cur_next;
            cur_idx_reg   <= cur_idx_next;
            cur_data_reg  <= cur_data_next;
            is_empty_reg  <= is_empty_next;
        end
    end

    // ports
    assign in_stall        = state_reg != S_IDLE;
    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign has_current     = has_cur_reg;
    assign current_index   = cur_idx_reg;
    assign current_payload = cur_data_reg;
    assign is_empty        = is_empty_reg;

endmodule

// ----- test/array_linked_list_manager_tb.sv -----
module array_linked_list_manager_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one reply as seen on the result port
    typedef struct {
        logic [2:0]                 status;
        logic                       has_current;
        logic [alm_pkg::IDX_W-1:0]  current_index;
        logic [alm_pkg::DATA_W-1:0] current_payload;
        logic                       is_empty;
    } list_reply_t;

    // shadow copy of the node store and the replies it predicts
    class list_scoreboard;
        logic [alm_pkg::DATA_W-1:0] node_data [alm_pkg::DEPTH];
        alm_pkg::ptr_t              node_next [alm_pkg::DEPTH];
        alm_pkg::ptr_t              head;
        alm_pkg::ptr_t              cur;
        alm_pkg::ptr_t              free_head;
        int unsigned                used;
        int unsigned                nodes;
        logic [31:0]                mask;
        list_reply_t                pending_replies [$];
        int                         errors;

        function new();
            foreach (node_data[i])
            begin
                node_data[i] = '0;
                node_next[i] = '0;
            end
            head      = alm_pkg::NIL;
            cur       = alm_pkg::NIL;
            free_head = alm_pkg::NIL;
            used      = 0;
            nodes     = 0;
            mask      = '1;
            errors    = 0;
        endfunction

        // push a released slot on the front of the free list
        function void free_slot(alm_pkg::ptr_t s);
            node_next[s] = free_head;
            free_head    = s;
            nodes--;
        endfunction

        // unlink the head, the next node becomes current
        function void drop_head();
            alm_pkg::ptr_t nx;
            nx = node_next[head];
            free_slot(head);
            head = nx;
            cur  = nx;
        endfunction

        // apply one accepted request and queue the reply it must produce
        function void note_request(alm_pkg::opcode_t op, logic [alm_pkg::DATA_W-1:0] d);
            alm_pkg::status_t st;
            alm_pkg::ptr_t    slot;
            alm_pkg::ptr_t    p;
            alm_pkg::ptr_t    prev;
            bit               found;
            int               n;
            list_reply_t      r;
            st = alm_pkg::ST_OK;
            case (op)
                alm_pkg::OP_INS_FRONT, alm_pkg::OP_INS_REAR:
                begin
                    if (free_head == alm_pkg::NIL && used >= alm_pkg::DEPTH)
                        st = alm_pkg::ST_FULL;
                    else
                    begin
                        // released slots first, then the next never-used one
                        if (free_head != alm_pkg::NIL)
                        begin
                            slot      = free_head;
                            free_head = node_next[slot];
                        end
                        else
                        begin
                            slot = alm_pkg::ptr_t'(used);
                            used++;
                        end
                        node_data[slot] = d;
                        if (op == alm_pkg::OP_INS_FRONT || head == alm_pkg::NIL)
                        begin
                            node_next[slot] = head;
                            head            = slot;
                        end
                        else
                        begin
                            p = head;
                            for (n = 0; n < alm_pkg::DEPTH && node_next[p] != alm_pkg::NIL;
                                 n++)
                                p = node_next[p];
                            node_next[slot] = alm_pkg::NIL;
                            node_next[p]    = slot;
                        end
                        cur = slot;
                        nodes++;
                    end
                end
                alm_pkg::OP_REM_FRONT:
                begin
                    if (head == alm_pkg::NIL)
                        st = alm_pkg::ST_EMPTY;
                    else
                        drop_head();
                end
                alm_pkg::OP_REM_REAR:
                begin
                    if (head == alm_pkg::NIL)
                        st = alm_pkg::ST_EMPTY;
                    else if (node_next[head] == alm_pkg::NIL)
                        drop_head();
                    else
                    begin
                        // walk to the tail, keeping the node before it
                        prev = alm_pkg::NIL;
                        p    = head;
                        for (n = 0; n < alm_pkg::DEPTH && node_next[p] != alm_pkg::NIL; n++)
                        begin
                            prev = p;
                            p    = node_next[p];
                        end
                        node_next[prev] = alm_pkg::NIL;
                        free_slot(p);
                        cur = prev;
                    end
                end
                alm_pkg::OP_REM_CUR:
                begin
                    if (head == alm_pkg::NIL)
                        st = alm_pkg::ST_EMPTY;
                    else if (cur == alm_pkg::NIL)
                        st = alm_pkg::ST_NO_CUR;
                    else if (cur == head)
                        drop_head();
                    else
                    begin
                        // find the predecessor of the current node
                        p = head;
                        for (n = 0; n < alm_pkg::DEPTH && p != alm_pkg::NIL
                                    && node_next[p] != cur; n++)
                            p = node_next[p];
                        if (p != alm_pkg::NIL && node_next[p] == cur)
                        begin
                            node_next[p] = node_next[cur];
                            free_slot(cur);
                            cur = p;
                        end
                        else
                            st = alm_pkg::ST_NO_CUR;
                    end
                end
                alm_pkg::OP_SEARCH:
                begin
                    if (head == alm_pkg::NIL)
                        st = alm_pkg::ST_EMPTY;
                    else
                    begin
                        // first masked match from the head wins
                        st    = alm_pkg::ST_NOT_FOUND;
                        found = 1'b0;
                        p     = head;
                        for (n = 0; n < alm_pkg::DEPTH && p != alm_pkg::NIL && !found; n++)
                        begin
                            if (((node_data[p] ^ d) & mask) == '0)
                            begin
                                cur   = p;
                                st    = alm_pkg::ST_OK;
                                found = 1'b1;
                            end
                            else
                                p = node_next[p];
                        end
                    end
                end
                alm_pkg::OP_CLEAR:
                begin
                    for (n = 0; n < alm_pkg::DEPTH && head != alm_pkg::NIL; n++)
                        drop_head();
                    head = alm_pkg::NIL;
                    cur  = alm_pkg::NIL;
                end
                default:
                    ;
            endcase

            r.status          = st;
            r.has_current     = (cur != alm_pkg::NIL);
            r.current_index   = (cur != alm_pkg::NIL) ? cur[alm_pkg::IDX_W-1:0] : '0;
            r.current_payload = (cur != alm_pkg::NIL) ? node_data[cur] : '0;
            r.is_empty        = (head == alm_pkg::NIL);
            pending_replies.push_back(r);
        endfunction

        // compare one accepted reply with the oldest prediction
        function void check_result(list_reply_t got);
            list_reply_t want;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: reply with no request outstanding, status %0d",
                         $time, got.status);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.has_current !== want.has_current)
            begin
                $display("%0t: has_current expected %0b, got %0b",
                         $time, want.has_current, got.has_current);
                errors++;
            end
            if (got.current_index !== want.current_index)
            begin
                $display("%0t: current_index expected %0d, got %0d",
                         $time, want.current_index, got.current_index);
                errors++;
            end
            if (got.current_payload !== want.current_payload)
            begin
                $display("%0t: current_payload expected %h, got %h",
                         $time, want.current_payload, got.current_payload);
                errors++;
            end
            if (got.is_empty !== want.is_empty)
            begin
                $display("%0t: is_empty expected %0b, got %0b",
                         $time, want.is_empty, got.is_empty);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_PCT      = 25;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int PHASE_ITEMS    = 60;

    logic                       clk             = 1'b0;
    logic                       rst_n           = 1'b0;
    logic                       in_valid        = 1'b0;
    logic                       in_stall;
    logic [2:0]                 opcode          = alm_pkg::OP_NOP;
    logic [alm_pkg::DATA_W-1:0] payload         = '0;
    logic                       out_valid;
    logic                       out_stall       = 1'b0;
    logic [2:0]                 status;
    logic                       has_current;
    logic [alm_pkg::IDX_W-1:0]  current_index;
    logic [alm_pkg::DATA_W-1:0] current_payload;
    logic                       is_empty;
    logic                       cfg_valid       = 1'b0;
    logic                       cfg_ready;
    logic [31:0]                match_mask      = '1;

    logic                       calm            = 1'b0;
    int                         idle_cycles     = 0;
    list_reply_t                reply_seen;
    list_scoreboard             sb;

    array_linked_list_manager i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .payload         (payload),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .has_current     (has_current),
        .current_index   (current_index),
        .current_payload (current_payload),
        .is_empty        (is_empty),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .match_mask      (match_mask)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // random back-pressure on the result side
    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(99) < STALL_PCT);

    // request and reply monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(alm_pkg::opcode_t'(opcode), payload);
            if (out_valid && !out_stall)
            begin
                reply_seen.status          = status;
                reply_seen.has_current     = has_current;
                reply_seen.current_index   = current_index;
                reply_seen.current_payload = current_payload;
                reply_seen.is_empty        = is_empty;
                sb.check_result(reply_seen);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // present one request and hold it until taken; valid stays high on return
    task automatic send_req(alm_pkg::opcode_t op, logic [alm_pkg::DATA_W-1:0] d);
        while (!calm && $urandom_range(99) < STALL_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        payload  <= d;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop sending and wait for every outstanding reply
    task automatic drain(int pause);
        in_valid <= 1'b0;
        while (sb.pending_replies.size() != 0)
            @(negedge clk);
        repeat (pause) @(negedge clk);
    endtask

    // mask write, only while the block is idle
    task automatic write_mask(logic [31:0] m);
        cfg_valid  <= 1'b1;
        match_mask <= m;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        sb.mask = m;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // insert data: half full-width random, half from a small pool for duplicates
    function automatic logic [alm_pkg::DATA_W-1:0] insert_data();
        if ($urandom_range(1))
            return $urandom();
        return alm_pkg::DATA_W'($urandom_range(7));
    endfunction

    // search key: mostly a stored value with the unmasked bits scrambled
    function automatic logic [alm_pkg::DATA_W-1:0] search_key();
        logic [alm_pkg::DATA_W-1:0] k;
        alm_pkg::ptr_t              p;
        int unsigned                hops;
        k = $urandom();
        if (sb.nodes != 0 && $urandom_range(9) < 7)
        begin
            p    = sb.head;
            hops = $urandom_range(sb.nodes - 1);
            repeat (hops) p = sb.node_next[p];
            k = (sb.node_data[p] & sb.mask) | (k & ~sb.mask);
        end
        return k;
    endfunction

    // opcode mix, leaning toward removals once the list grows
    function automatic alm_pkg::opcode_t pick_op(int unsigned len);
        int unsigned r;
        r = $urandom_range(99);
        if (len > 20 && r < 40)
            r = r + 40;
        if (r < 22)
            return alm_pkg::OP_INS_FRONT;
        if (r < 40)
            return alm_pkg::OP_INS_REAR;
        if (r < 52)
            return alm_pkg::OP_REM_FRONT;
        if (r < 62)
            return alm_pkg::OP_REM_REAR;
        if (r < 72)
            return alm_pkg::OP_REM_CUR;
        if (r < 95)
            return alm_pkg::OP_SEARCH;
        if (r < 98)
            return alm_pkg::OP_CLEAR;
        return alm_pkg::OP_NOP;
    endfunction

    // random request stream
    task automatic run_phase(int count);
        alm_pkg::opcode_t           op;
        logic [alm_pkg::DATA_W-1:0] d;
        for (int i = 0; i < count; i++)
        begin
            op = pick_op(sb.nodes);
            case (op)
                alm_pkg::OP_INS_FRONT, alm_pkg::OP_INS_REAR:
                    d = insert_data();
                alm_pkg::OP_SEARCH:
                    d = search_key();
                default:
                    d = $urandom();
            endcase
            send_req(op, d);
        end
    endtask

    initial
    begin
        logic [31:0] m;
        sb = new();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every removal and search on an empty list, clear and nop too
        send_req(alm_pkg::OP_REM_FRONT, 32'h0000_0000);
        send_req(alm_pkg::OP_REM_REAR, 32'hFFFF_FFFF);
        send_req(alm_pkg::OP_REM_CUR, 32'h0000_0000);
        send_req(alm_pkg::OP_SEARCH, 32'hFFFF_FFFF);
        send_req(alm_pkg::OP_CLEAR, 32'h0000_0000);
        send_req(alm_pkg::OP_NOP, 32'hFFFF_FFFF);

        // small list with payload extremes
        send_req(alm_pkg::OP_INS_FRONT, 32'h0000_0000);
        send_req(alm_pkg::OP_INS_REAR, 32'hFFFF_FFFF);
        send_req(alm_pkg::OP_INS_FRONT, 32'hA5A5_A5A5);
        send_req(alm_pkg::OP_INS_REAR, 32'h5A5A_5A5A);
        send_req(alm_pkg::OP_SEARCH, 32'hFFFF_FFFF);
        send_req(alm_pkg::OP_SEARCH, 32'h1234_5678);
        send_req(alm_pkg::OP_REM_CUR, 32'h0000_0000);
        send_req(alm_pkg::OP_SEARCH, 32'hA5A5_A5A5);
        send_req(alm_pkg::OP_REM_CUR, 32'h0000_0000);
        send_req(alm_pkg::OP_REM_REAR, 32'h0000_0000);
        send_req(alm_pkg::OP_REM_REAR, 32'h0000_0000);
        send_req(alm_pkg::OP_INS_REAR, 32'h8000_0001);
        send_req(alm_pkg::OP_REM_FRONT, 32'h0000_0000);
        send_req(alm_pkg::OP_INS_REAR, 32'h1234_5678);
        send_req(alm_pkg::OP_INS_FRONT, 32'h0000_0078);
        drain(16);

        // mask extremes: empty mask matches the head, a mask without the low byte picks a later node
        write_mask(32'h0000_0000);
        send_req(alm_pkg::OP_SEARCH, 32'hDEAD_BEEF);
        drain(16);
        write_mask(32'hFFFF_FF00);
        send_req(alm_pkg::OP_SEARCH, 32'h1234_56FF);
        send_req(alm_pkg::OP_CLEAR, 32'h0000_0000);

        // random phases, each with its own mask
        for (int phase = 0; phase < 10; phase++)
        begin
            drain(16);
            case (phase % 6)
                0: m = 32'hFFFF_FFFF;
                1: m = 32'h0000_0000;
                2: m = 32'h0000_000F;
                3: m = 32'h0000_0001 << $urandom_range(31);
                4: m = 32'h8000_0000;
                default: m = $urandom();
            endcase
            write_mask(m);
            calm <= (phase == 4);
            run_phase(PHASE_ITEMS);

            // fill the store, hit refusals, then walk and clear a full list
            if (phase == 5)
            begin
                drain(16);
                while (sb.nodes < alm_pkg::DEPTH)
                    send_req(alm_pkg::OP_INS_FRONT, insert_data());
                send_req(alm_pkg::OP_INS_FRONT, $urandom());
                send_req(alm_pkg::OP_INS_REAR, $urandom());
                send_req(alm_pkg::OP_SEARCH, search_key());
                send_req(alm_pkg::OP_REM_REAR, $urandom());
                send_req(alm_pkg::OP_INS_REAR, $urandom());
                send_req(alm_pkg::OP_INS_FRONT, $urandom());
                send_req(alm_pkg::OP_REM_CUR, $urandom());
                send_req(alm_pkg::OP_SEARCH, search_key());
                send_req(alm_pkg::OP_CLEAR, $urandom());
            end
        end

        drain(SETTLE_CYCLES);
        if (sb.errors == 0 && sb.pending_replies.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
